@@ rtl/vu_pkg.sv @@
`timescale 1ns / 1ps
// vu_pkg: shared types, constants and helpers of the VU level meter
package vu_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int SUM_W      = SAMPLE_W + 1;
  localparam int COEFF_W    = 24;
  localparam int GAIN_W     = COEFF_W + 1;
  localparam int FULL_W     = GAIN_W + SUM_W;
  localparam int PROD_W     = SAMPLE_W + COEFF_W + 1;
  localparam int LEVEL_W    = 40;
  localparam int ACC_W      = COEFF_W + LEVEL_W;
  localparam int MEAN_SH    = LEVEL_W - 1 - SAMPLE_W;

  localparam logic [GAIN_W-1:0]  COEFF_ONE = GAIN_W'(1) << COEFF_W;
  localparam logic [ACC_W-1:0]   ACC_HALF  = ACC_W'(1) << (COEFF_W - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(1) << (LEVEL_W - 1);

  localparam int POS_W      = 6;
  localparam int MANT_W     = 31;
  localparam int SQ_W       = 2 * MANT_W;
  localparam int FRAC_W     = 16;
  localparam int ATT_W      = POS_W + FRAC_W;
  localparam int LOG_K_W    = 23;
  localparam int ATT_PROD_W = ATT_W + LOG_K_W;
  localparam int ATT_RND_W  = ATT_PROD_W + 1;
  localparam int ATT_SH     = 32;
  localparam int ATT16_W    = ATT_RND_W - ATT_SH;

  localparam logic [LOG_K_W-1:0]   LOG_K    = 23'd6313057;
  localparam logic [ATT_RND_W-1:0] ATT_HALF = ATT_RND_W'(1) << (ATT_SH - 1);

  localparam int VU_W = 10;
  localparam int VU_WIDE_W = VU_W + 1;
  localparam logic signed [VU_WIDE_W-1:0] VU_OFFSET = 11'sd288;
  localparam logic signed [VU_WIDE_W-1:0] VU_MAX_W  = 11'sd48;
  localparam logic signed [VU_W-1:0]      VU_MIN    = -10'sd320;
  localparam logic signed [VU_W-1:0]      VU_MAX    = 10'sd48;
  localparam logic [ATT16_W-1:0]          VU_SPAN   = 14'd608;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THR = 2'd2;

  localparam int CH_W = 2;
  localparam logic [CH_W-1:0] CH_MONO = 2'd1;

  localparam logic [COEFF_W-1:0]   SMOOTH_RST = 24'd16776051;
  localparam logic [CH_W-1:0]      CH_RST     = 2'd2;
  localparam logic signed [VU_W-1:0] THR_RST  = 10'sd0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic                       end_of_block;
  } vu_in_t;

  typedef struct packed {
    logic signed [VU_W-1:0] vu_reading;
    logic                   peak_hit;
  } vu_out_t;

  typedef struct packed {
    logic [COEFF_W-1:0]     smoothing_coeff;
    logic [CH_W-1:0]        channel_count;
    logic signed [VU_W-1:0] peak_threshold;
  } vu_cfg_t;

  typedef struct packed {
    logic vld;
    logic eob;
  } vu_tag_t;

  function automatic logic [SAMPLE_W-1:0] sample_mag(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] u;
    u = s;
    return u[SAMPLE_W-1] ? (~u + SAMPLE_W'(1)) : u;
  endfunction

endpackage

@@ rtl/vu_mean.sv @@
`timescale 1ns / 1ps
// vu_mean: input register, channel mean and weighting of the new sample
module vu_mean (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  vu_pkg::vu_in_t              in_item,
  input  vu_pkg::vu_cfg_t             cfg,
  output vu_pkg::vu_tag_t             tag_o,
  output logic [vu_pkg::PROD_W-1:0]   prod_o
);

  logic [vu_pkg::SAMPLE_W-1:0] mag_l;
  logic [vu_pkg::SAMPLE_W-1:0] mag_r;
  logic [vu_pkg::SUM_W-1:0]    sum_nxt;
  logic [vu_pkg::SUM_W-1:0]    sum_a_r;
  logic                        vld_a_r;
  logic                        eob_a_r;
  logic [vu_pkg::GAIN_W-1:0]   gain;
  logic [vu_pkg::FULL_W-1:0]   prod_full;
  logic [vu_pkg::PROD_W-1:0]   prod_b_r;
  logic                        vld_b_r;
  logic                        eob_b_r;

  assign mag_l = vu_pkg::sample_mag(in_item.sample_left);
  assign mag_r = vu_pkg::sample_mag(in_item.sample_right);

  always_comb begin
    if (cfg.channel_count == vu_pkg::CH_MONO) begin
      sum_nxt = {mag_l, 1'b0};
    end else begin
      sum_nxt = {1'b0, mag_l} + {1'b0, mag_r};
    end
  end

  assign gain      = vu_pkg::COEFF_ONE - {1'b0, cfg.smoothing_coeff};
  assign prod_full = vu_pkg::FULL_W'(gain) * vu_pkg::FULL_W'(sum_a_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= in_fire;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sum_a_r <= sum_nxt;
      eob_a_r <= in_item.end_of_block;
    end
    if (vld_a_r) begin
      prod_b_r <= prod_full[vu_pkg::PROD_W-1:0];
      eob_b_r  <= eob_a_r;
    end
  end

  assign tag_o  = '{vld: vld_b_r, eob: eob_b_r};
  assign prod_o = prod_b_r;

endmodule

@@ rtl/vu_integ.sv @@
`timescale 1ns / 1ps
// vu_integ: one-pole level integrator
module vu_integ (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vu_pkg::vu_tag_t             tag_i,
  input  logic [vu_pkg::PROD_W-1:0]   prod_i,
  input  vu_pkg::vu_cfg_t             cfg,
  output vu_pkg::vu_tag_t             tag_o,
  output logic [vu_pkg::LEVEL_W-1:0]  level_o
);

  logic [vu_pkg::ACC_W-1:0]   a_by_i;
  logic [vu_pkg::ACC_W-1:0]   mean_term;
  logic [vu_pkg::ACC_W-1:0]   acc;
  logic [vu_pkg::LEVEL_W-1:0] level_nxt;
  logic [vu_pkg::LEVEL_W-1:0] level_r;
  logic                       vld_c_r;
  logic                       eob_c_r;

  assign a_by_i    = vu_pkg::ACC_W'(cfg.smoothing_coeff) * vu_pkg::ACC_W'(level_r);
  assign mean_term = {prod_i, {vu_pkg::MEAN_SH{1'b0}}};
  assign acc       = a_by_i + mean_term + vu_pkg::ACC_HALF;
  assign level_nxt = acc[vu_pkg::ACC_W-1:vu_pkg::COEFF_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      level_r <= '0;
    end else begin
      vld_c_r <= tag_i.vld;
      if (tag_i.vld) begin
        level_r <= level_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_i.vld) begin
      eob_c_r <= tag_i.eob;
    end
  end

  assign tag_o   = '{vld: vld_c_r, eob: eob_c_r};
  assign level_o = level_r;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= vu_pkg::LEVEL_MAX)
    else $error("integrator above full scale");

endmodule

@@ rtl/vu_log.sv @@
`timescale 1ns / 1ps
// vu_log: level to VU reading conversion pipeline
module vu_log (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vu_pkg::vu_tag_t             tag_i,
  input  logic [vu_pkg::LEVEL_W-1:0]  level_i,
  input  vu_pkg::vu_cfg_t             cfg,
  output logic                        res_vld_o,
  output vu_pkg::vu_out_t             res_o
);

  localparam int NST = vu_pkg::FRAC_W;

  logic [vu_pkg::LEVEL_W-1:0]  norm;
  logic [vu_pkg::POS_W-1:0]    lz;

  logic                        sq_vld_r  [0:NST];
  logic                        sq_zero_r [0:NST];
  logic [vu_pkg::POS_W-1:0]    sq_lz_r   [0:NST];
  logic [vu_pkg::MANT_W-1:0]   sq_m_r    [0:NST];
  logic [vu_pkg::FRAC_W-1:0]   sq_f_r    [0:NST];

  logic [vu_pkg::SQ_W-1:0]     sq_prod [NST];
  logic [vu_pkg::MANT_W:0]     sq_top  [NST];
  logic [vu_pkg::MANT_W-1:0]   m_nxt   [NST];
  logic [vu_pkg::FRAC_W-1:0]   f_nxt   [NST];

  logic [vu_pkg::ATT_W-1:0]      att;
  logic [vu_pkg::ATT_PROD_W-1:0] mul_nxt;
  logic [vu_pkg::ATT_PROD_W-1:0] mul_r;
  logic                          mvld_r;
  logic                          mzero_r;

  logic [vu_pkg::ATT_RND_W-1:0]       rnd;
  logic [vu_pkg::ATT16_W-1:0]         att16;
  logic signed [vu_pkg::VU_WIDE_W-1:0] diff;
  logic signed [vu_pkg::VU_W-1:0]     vu_nxt;
  logic                               res_vld_r;
  vu_pkg::vu_out_t                    res_r;

  // left-justify the level, counting leading zeros
  always_comb begin
    norm = level_i;
    lz   = '0;
    for (int k = vu_pkg::POS_W - 1; k >= 0; k--) begin
      if ((norm >> (vu_pkg::LEVEL_W - (1 << k))) == '0) begin
        norm = norm << (1 << k);
        lz   = lz + vu_pkg::POS_W'(1 << k);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NST; j++) begin
      sq_prod[j] = vu_pkg::SQ_W'(sq_m_r[j]) * vu_pkg::SQ_W'(sq_m_r[j]);
      sq_top[j]  = sq_prod[j][vu_pkg::SQ_W-1:vu_pkg::MANT_W-1];
      m_nxt[j]   = sq_top[j][vu_pkg::MANT_W] ? sq_top[j][vu_pkg::MANT_W:1]
                                             : sq_top[j][vu_pkg::MANT_W-1:0];
      f_nxt[j]   = {sq_f_r[j][vu_pkg::FRAC_W-2:0], sq_top[j][vu_pkg::MANT_W]};
    end
  end

  assign att     = {sq_lz_r[NST], {vu_pkg::FRAC_W{1'b0}}} - vu_pkg::ATT_W'(sq_f_r[NST]);
  assign mul_nxt = vu_pkg::ATT_PROD_W'(att) * vu_pkg::ATT_PROD_W'(vu_pkg::LOG_K);

  assign rnd   = {1'b0, mul_r} + vu_pkg::ATT_HALF;
  assign att16 = rnd[vu_pkg::ATT_RND_W-1:vu_pkg::ATT_SH];
  assign diff  = vu_pkg::VU_OFFSET - $signed({1'b0, att16[vu_pkg::VU_W-1:0]});

  always_comb begin
    if (mzero_r || (att16 > vu_pkg::VU_SPAN)) begin
      vu_nxt = vu_pkg::VU_MIN;
    end else if (diff > vu_pkg::VU_MAX_W) begin
      vu_nxt = vu_pkg::VU_MAX;
    end else begin
      vu_nxt = diff[vu_pkg::VU_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NST; j++) begin
        sq_vld_r[j] <= 1'b0;
      end
      mvld_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      sq_vld_r[0] <= tag_i.vld && tag_i.eob;
      for (int j = 0; j < NST; j++) begin
        sq_vld_r[j+1] <= sq_vld_r[j];
      end
      mvld_r    <= sq_vld_r[NST];
      res_vld_r <= mvld_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_zero_r[0] <= (level_i == '0);
    sq_lz_r[0]   <= lz;
    sq_m_r[0]    <= norm[vu_pkg::LEVEL_W-1:vu_pkg::LEVEL_W-vu_pkg::MANT_W];
    sq_f_r[0]    <= '0;
    for (int j = 0; j < NST; j++) begin
      sq_zero_r[j+1] <= sq_zero_r[j];
      sq_lz_r[j+1]   <= sq_lz_r[j];
      sq_m_r[j+1]    <= m_nxt[j];
      sq_f_r[j+1]    <= f_nxt[j];
    end
    mul_r   <= mul_nxt;
    mzero_r <= sq_zero_r[NST];
    res_r.vu_reading <= vu_nxt;
    res_r.peak_hit   <= (vu_nxt >= cfg.peak_threshold);
  end

  assign res_vld_o = res_vld_r;
  assign res_o     = res_r;

  a_reading_max: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> (res_r.vu_reading <= vu_pkg::VU_MAX))
    else $error("reading above +3 dB");

  a_zero_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (mvld_r && mzero_r) |=> (res_r.vu_reading == vu_pkg::VU_MIN))
    else $error("silent level not at floor");

endmodule

@@ rtl/vu_ofifo.sv @@
`timescale 1ns / 1ps
// vu_ofifo: result queue with registered output stage
module vu_ofifo #(
  parameter int DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  vu_pkg::vu_out_t wr_item,
  output logic            out_valid,
  input  logic            out_ready,
  output vu_pkg::vu_out_t out_item
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  vu_pkg::vu_out_t  mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             out_valid_r;
  vu_pkg::vu_out_t  out_item_r;
  logic             load;

  assign load = (count_r != '0) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (load) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      count_r <= count_r + CNT_W'(wr_en) - CNT_W'(load);
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_item;
    end
    if (load) begin
      out_item_r <= mem[rd_ptr_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((count_r < CNT_W'(DEPTH)) || load))
    else $error("result queue overflow");

endmodule

@@ rtl/vu_level_meter_core.sv @@
`timescale 1ns / 1ps
// vu_level_meter_core: VU level meter top level
//
//  channel | ports                          | payload
//  --------+--------------------------------+-------------------------------------
//  input   | in_valid / in_ready            | in_data: sample pair, end_of_block
//  result  | out_valid / out_ready          | out_data: vu_reading, peak_hit
//  config  | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
//  One item per clock while in_ready; multiply-add loop closes through level_r.
//  Each end-of-block item's reading passes mean, integ, log, queue registers.
//  Reset: synchronous, active low; integrator cleared, registers at defaults.
//  in_ready falls only while FIFO_DEPTH readings wait in flight or in the queue.
//  cfg_ready is always high.
module vu_level_meter_core #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vu_pkg::vu_in_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vu_pkg::vu_out_t                 out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

  vu_pkg::vu_cfg_t                 cfg_r;
  logic [PEND_W-1:0]               pend_r;
  logic                            in_fire;
  logic                            out_fire;
  vu_pkg::vu_tag_t                 mean_tag;
  logic [vu_pkg::PROD_W-1:0]       mean_prod;
  vu_pkg::vu_tag_t                 integ_tag;
  logic [vu_pkg::LEVEL_W-1:0]      level;
  logic                            res_vld;
  vu_pkg::vu_out_t                 res;

  assign cfg_ready = 1'b1;
  assign in_ready  = pend_r < PEND_W'(FIFO_DEPTH);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smoothing_coeff <= vu_pkg::SMOOTH_RST;
      cfg_r.channel_count   <= vu_pkg::CH_RST;
      cfg_r.peak_threshold  <= vu_pkg::THR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        vu_pkg::CFG_SMOOTH:   cfg_r.smoothing_coeff <= cfg_data[vu_pkg::COEFF_W-1:0];
        vu_pkg::CFG_CHANNELS: cfg_r.channel_count   <= cfg_data[vu_pkg::CH_W-1:0];
        vu_pkg::CFG_PEAK_THR: cfg_r.peak_threshold  <= $signed(cfg_data[vu_pkg::VU_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + PEND_W'(in_fire && in_data.end_of_block) - PEND_W'(out_fire);
    end
  end

  vu_mean u_mean (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_data),
    .cfg     (cfg_r),
    .tag_o   (mean_tag),
    .prod_o  (mean_prod)
  );

  vu_integ u_integ (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_i   (mean_tag),
    .prod_i  (mean_prod),
    .cfg     (cfg_r),
    .tag_o   (integ_tag),
    .level_o (level)
  );

  vu_log u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (integ_tag),
    .level_i   (level),
    .cfg       (cfg_r),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  vu_ofifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res_vld),
    .wr_item   (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("result without pending item");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(FIFO_DEPTH))
    else $error("pending count above queue depth");

endmodule
